// ----- sv/spm_pkg.sv -----
// ---------------------------------------------------------------------------
// spm_pkg
// Shared widths, register indexes and types for the sphere point map.
// ---------------------------------------------------------------------------
`default_nettype none
package spm_pkg;
	localparam int COORD_BITS = 14;
	localparam int COEF_W     = 20;
	localparam int FIX_W      = 20;
	localparam int VEC_W      = 21;
	localparam int PROD_W     = COEF_W + VEC_W;
	localparam int DOT_W      = PROD_W + 2;
	localparam int MAG_W      = DOT_W;
	localparam int NUM_W      = MAG_W + FIX_W;
	localparam int QUO_W      = 32;
	localparam int REM_W      = NUM_W + 5 + 7;
	localparam int OUT_W      = 28;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;
	localparam int FRONT_LAT  = 3;
	localparam int PROJ_LAT   = QUO_W + 3;
	localparam int TOTAL_LAT  = FRONT_LAT + PROJ_LAT;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0    = 3'd0,
		REG_ROW1    = 3'd1,
		REG_ROW2    = 3'd2,
		REG_SRC_C   = 3'd3,
		REG_SRC_R   = 3'd4,
		REG_DST_C   = 3'd5,
		REG_DST_R   = 3'd6,
		REG_UNUSED  = 3'd7
	} cfg_reg_t;

	typedef logic [3*COEF_W-1:0] mat_row_t;
endpackage
`default_nettype wire

// ----- sv/spm_matvec.sv -----
// ---------------------------------------------------------------------------
// spm_matvec
// Centers the pixel and multiplies it by the 3x3 matrix in three stages.
// ---------------------------------------------------------------------------
`default_nettype none
module spm_matvec (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [spm_pkg::COORD_BITS-1:0]    pix_x,
	input  wire logic [spm_pkg::COORD_BITS-1:0]    pix_y,
	input  wire spm_pkg::mat_row_t                 row0,
	input  wire spm_pkg::mat_row_t                 row1,
	input  wire spm_pkg::mat_row_t                 row2,
	input  wire logic [2*spm_pkg::FIX_W-1:0]       src_c,
	input  wire logic [spm_pkg::FIX_W-1:0]         src_r,
	output logic signed [spm_pkg::DOT_W-1:0]       v0,
	output logic signed [spm_pkg::DOT_W-1:0]       v1,
	output logic signed [spm_pkg::DOT_W-1:0]       v2
);
	localparam int VW = spm_pkg::VEC_W;
	localparam int PW = spm_pkg::PROD_W;
	localparam int DW = spm_pkg::DOT_W;
	localparam int CW = spm_pkg::COEF_W;

	logic signed [VW-1:0] vec_s1 [3];
	logic signed [PW-1:0] prod_s2 [9];
	logic signed [DW-1:0] dot_s3 [3];
	spm_pkg::mat_row_t    rows [3];

	assign rows[0] = row0;
	assign rows[1] = row1;
	assign rows[2] = row2;

	// center the pixel, radius becomes z
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1[0] <= $signed(VW'({pix_x, 4'b0000})) - $signed(VW'(src_c[19:0]));
			vec_s1[1] <= $signed(VW'({pix_y, 4'b0000})) - $signed(VW'(src_c[39:20]));
			vec_s1[2] <= $signed(VW'(src_r));
		end
	end

	// nine coefficient products
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s2[3*i+j] <= $signed(rows[i][CW*j +: CW]) * vec_s1[j];
				end
			end
		end
		// row sums
		always_ff @(posedge clk) begin
			if (en) begin
				dot_s3[i] <= DW'(prod_s2[3*i]) + DW'(prod_s2[3*i+1]) + DW'(prod_s2[3*i+2]);
			end
		end
	end

	assign v0 = dot_s3[0];
	assign v1 = dot_s3[1];
	assign v2 = dot_s3[2];
endmodule
`default_nettype wire

// ----- sv/spm_proj.sv -----
// ---------------------------------------------------------------------------
// spm_proj
// Scales one component by the radius, divides by z in a bit-per-stage
// pipeline, rounds, adds the center and saturates.
// ---------------------------------------------------------------------------
`default_nettype none
module spm_proj (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [spm_pkg::DOT_W-1:0]  num,
	input  wire logic signed [spm_pkg::DOT_W-1:0]  den,
	input  wire logic [spm_pkg::FIX_W-1:0]         dst_r,
	input  wire logic [spm_pkg::FIX_W-1:0]         dst_c,
	output logic signed [spm_pkg::OUT_W-1:0]       res,
	output logic                                   flag
);
	localparam int MW = spm_pkg::MAG_W;
	localparam int NW = spm_pkg::NUM_W;
	localparam int QW = spm_pkg::QUO_W;
	localparam int RW = spm_pkg::REM_W;
	localparam int OW = spm_pkg::OUT_W;
	localparam int SW = QW + 2;
	localparam logic signed [SW-1:0] OMAX = SW'((64'sd1 <<< (OW-1)) - 1);
	localparam logic signed [SW-1:0] OMIN = -SW'(64'sd1 <<< (OW-1));

	logic [NW-1:0] n_s1;
	logic [MW-1:0] d_s1;
	logic          neg_s1, nneg_s1, zden_s1;

	logic [RW-1:0] rem_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [MW-1:0] div_s [QW+1];
	logic          neg_s [QW+1];
	logic          nneg_s [QW+1];
	logic          zden_s [QW+1];
	logic          ovf_s [QW+1];

	logic [QW:0]          rnd;
	logic [QW-1:0]        mag;
	logic signed [SW-1:0] val;

	// take magnitudes and scale the numerator
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= NW'(num[MW-1] ? MW'(-num) : MW'(num)) * NW'(dst_r);
			d_s1    <= den[MW-1] ? MW'(-den) : MW'(den);
			neg_s1  <= num[MW-1] != den[MW-1];
			nneg_s1 <= num[MW-1];
			zden_s1 <= den == '0;
		end
	end

	// check quotient range, load the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= RW'({n_s1, 5'b00000});
			quo_s[0]  <= '0;
			div_s[0]  <= d_s1;
			neg_s[0]  <= neg_s1;
			nneg_s[0] <= nneg_s1;
			zden_s[0] <= zden_s1;
			ovf_s[0]  <= (RW'(n_s1) >= (RW'(d_s1) << 27)) && !zden_s1;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [RW-1:0] trial;
		assign trial = RW'(div_s[k]) << (QW-1-k);
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial;
					quo_s[k+1] <= quo_s[k] | (QW'(1) << (QW-1-k));
				end else begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= quo_s[k];
				end
				div_s[k+1]  <= div_s[k];
				neg_s[k+1]  <= neg_s[k];
				nneg_s[k+1] <= nneg_s[k];
				zden_s[k+1] <= zden_s[k];
				ovf_s[k+1]  <= ovf_s[k];
			end
		end
	end

	// round half away, restore sign, add center
	always_comb begin
		rnd = ({1'b0, quo_s[QW]} + (QW+1)'(1)) >> 1;
		mag = rnd[QW-1:0];
		val = (neg_s[QW] && mag != '0) ? -SW'({2'b00, mag}) : SW'({2'b00, mag});
		val = val + SW'({dst_c, 4'b0000});
	end

	// saturate
	always_ff @(posedge clk) begin
		if (en) begin
			if (zden_s[QW]) begin
				res  <= nneg_s[QW] ? OW'(OMIN) : OW'(OMAX);
				flag <= 1'b1;
			end else if (ovf_s[QW]) begin
				res  <= neg_s[QW] ? OW'(OMIN) : OW'(OMAX);
				flag <= 1'b1;
			end else if (val > OMAX) begin
				res  <= OW'(OMAX);
				flag <= 1'b1;
			end else if (val < OMIN) begin
				res  <= OW'(OMIN);
				flag <= 1'b1;
			end else begin
				res  <= OW'(val);
				flag <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/sphere_point_perspective_map.sv -----
// Depth: 38 register stages between an accepted request and its result.
// Throughput: one request per cycle while the output is not stalled; the 32-stage
// divider (one quotient bit per stage) sets most of the depth, and one enable drives all stages.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset clears valid bits and loads the identity matrix, zero centers
// and unit radii.
// ---------------------------------------------------------------------------
// sphere_point_perspective_map
// Rotates a pixel about the source sphere and projects it to the target.
// ---------------------------------------------------------------------------
`default_nettype none
module sphere_point_perspective_map (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [spm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [spm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [spm_pkg::COORD_BITS-1:0]       pix_x,
	input  wire logic [spm_pkg::COORD_BITS-1:0]       pix_y,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [spm_pkg::OUT_W-1:0]          out_x,
	output logic signed [spm_pkg::OUT_W-1:0]          out_y,
	output logic                                      saturated
);
	localparam int LAT = spm_pkg::TOTAL_LAT;
	localparam int FW  = spm_pkg::FIX_W;
	localparam int DW  = spm_pkg::DOT_W;

	spm_pkg::mat_row_t   row0_q, row1_q, row2_q;
	logic [2*FW-1:0]     src_c_q, dst_c_q;
	logic [FW-1:0]       src_r_q, dst_r_q;
	logic [LAT-1:0]      vld_q;
	logic                en;
	logic signed [DW-1:0] v0, v1, v2;
	logic                flag_x, flag_y;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q  <= spm_pkg::mat_row_t'(60'd262144);
			row1_q  <= spm_pkg::mat_row_t'(60'd262144 << 20);
			row2_q  <= spm_pkg::mat_row_t'(60'd262144 << 40);
			src_c_q <= '0;
			src_r_q <= FW'(16);
			dst_c_q <= '0;
			dst_r_q <= FW'(16);
		end else if (cfg_valid) begin
			case (spm_pkg::cfg_reg_t'(cfg_index))
				spm_pkg::REG_ROW0:  row0_q  <= cfg_data;
				spm_pkg::REG_ROW1:  row1_q  <= cfg_data;
				spm_pkg::REG_ROW2:  row2_q  <= cfg_data;
				spm_pkg::REG_SRC_C: src_c_q <= cfg_data[2*FW-1:0];
				spm_pkg::REG_SRC_R: src_r_q <= cfg_data[FW-1:0];
				spm_pkg::REG_DST_C: dst_c_q <= cfg_data[2*FW-1:0];
				spm_pkg::REG_DST_R: dst_r_q <= cfg_data[FW-1:0];
				default: ;
			endcase
		end
	end

	// advance the pipeline unless the result is held
	assign en       = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	spm_matvec u_matvec (
		.clk   (clk),
		.en    (en),
		.pix_x (pix_x),
		.pix_y (pix_y),
		.row0  (row0_q),
		.row1  (row1_q),
		.row2  (row2_q),
		.src_c (src_c_q),
		.src_r (src_r_q),
		.v0    (v0),
		.v1    (v1),
		.v2    (v2)
	);

	spm_proj u_proj_x (
		.clk   (clk),
		.en    (en),
		.num   (v0),
		.den   (v2),
		.dst_r (dst_r_q),
		.dst_c (dst_c_q[FW-1:0]),
		.res   (out_x),
		.flag  (flag_x)
	);

	spm_proj u_proj_y (
		.clk   (clk),
		.en    (en),
		.num   (v1),
		.den   (v2),
		.dst_r (dst_r_q),
		.dst_c (dst_c_q[2*FW-1:FW]),
		.res   (out_y),
		.flag  (flag_y)
	);

	assign out_valid = vld_q[LAT-1];
	assign saturated = flag_x | flag_y;
endmodule
`default_nettype wire

// ----- tb/sphere_point_perspective_map_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sphere_point_perspective_map_tb
// Drives pixel requests through several matrix, center and radius settings,
// predicts each mapped point in fixed point and checks every result in order
// under random source gaps and sink stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module sphere_point_perspective_map_tb;

	localparam int N_RANDOM = 1800;
	localparam int PHASES = 6;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint O_MAX = 134217727;
	localparam longint O_MIN = -134217728;

	typedef struct packed {
		logic [spm_pkg::COORD_BITS-1:0] px;
		logic [spm_pkg::COORD_BITS-1:0] py;
	} pix_req_t;

	typedef struct packed {
		logic signed [spm_pkg::OUT_W-1:0] ox;
		logic signed [spm_pkg::OUT_W-1:0] oy;
		logic                             sat;
	} point_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [spm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [spm_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [spm_pkg::COORD_BITS-1:0] pix_x;
	logic [spm_pkg::COORD_BITS-1:0] pix_y;
	logic out_valid;
	logic out_ready;
	logic signed [spm_pkg::OUT_W-1:0] out_x;
	logic signed [spm_pkg::OUT_W-1:0] out_y;
	logic saturated;

	// predictor copy of the register file
	logic [59:0] m_row [3];
	logic [39:0] s_cen;
	logic [19:0] s_rad;
	logic [39:0] d_cen;
	logic [19:0] d_rad;

	pix_req_t pending_pix[$];
	point_t   expected_points[$];
	int  errors;
	bit  quiet;
	bit  cfg_pend;
	spm_pkg::cfg_reg_t cfg_pend_idx;
	logic [59:0] cfg_pend_data;
	longint cycles;

	sphere_point_perspective_map uut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint coef_of(logic [59:0] row, int j);
		logic signed [19:0] c;
		c = row[20*j +: 20];
		return longint'(c);
	endfunction

	// divide, scale, round and add the center for one axis
	function automatic longint project_axis(longint num, longint den, logic [19:0] cen,
			ref bit flag);
		bit neg;
		longint unsigned n, d, q1, r1, t, mag;
		longint val;
		if (den == 0) begin
			flag = 1;
			return (num < 0) ? O_MIN : O_MAX;
		end
		neg = (num < 0) != (den < 0);
		n = longint'(num < 0 ? -num : num) * longint'(d_rad);
		d = (den < 0) ? -den : den;
		q1 = n / d;
		r1 = n % d;
		if (q1 >= (64'd1 << 27)) begin
			flag = 1;
			return neg ? O_MIN : O_MAX;
		end
		t = (r1 * 32) / d;
		mag = (q1 * 32 + t + 1) >> 1;
		if (mag == 0) neg = 0;
		val = neg ? -longint'(mag) : longint'(mag);
		val += longint'({cen, 4'b0});
		if (val > O_MAX) begin
			flag = 1;
			return O_MAX;
		end
		if (val < O_MIN) begin
			flag = 1;
			return O_MIN;
		end
		return val;
	endfunction

	function automatic point_t map_point(pix_req_t r);
		longint xs, ys, zs, v[3];
		bit flag;
		point_t p;
		xs = longint'({r.px, 4'b0}) - longint'(s_cen[19:0]);
		ys = longint'({r.py, 4'b0}) - longint'(s_cen[39:20]);
		zs = longint'(s_rad);
		for (int i = 0; i < 3; i++)
			v[i] = coef_of(m_row[i], 0) * xs + coef_of(m_row[i], 1) * ys
				+ coef_of(m_row[i], 2) * zs;
		flag = 0;
		p.ox = spm_pkg::OUT_W'(project_axis(v[0], v[2], d_cen[19:0], flag));
		p.oy = spm_pkg::OUT_W'(project_axis(v[1], v[2], d_cen[39:20], flag));
		p.sat = flag;
		return p;
	endfunction

	function automatic logic [19:0] rnd_coef();
		case ($urandom_range(0, 5))
			0: return 20'h40000;
			1: return 20'hC0000;
			2: return 20'h00000;
			3: return 20'h7FFFF;
			4: return 20'h80000;
			default: return 20'($urandom_range(0, 20'hFFFFF));
		endcase
	endfunction

	function automatic bit idle_now();
		return !quiet && ($urandom_range(0, 99) < 29);
	endfunction

	// drive requests; a queued register write goes out while the pipe is empty
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			pix_x <= '0;
			pix_y <= '0;
			cfg_valid <= 0;
			cfg_index <= spm_pkg::REG_ROW0;
			cfg_data <= '0;
		end else begin
			if (cfg_valid && cfg_ready) cfg_valid <= 0;
			else if (!cfg_valid && cfg_pend) begin
				cfg_valid <= 1;
				cfg_index <= cfg_pend_idx;
				cfg_data <= cfg_pend_data;
			end
			if (!in_valid || in_ready) begin
				if (in_valid) expected_points.push_back(map_point({pix_x, pix_y}));
				if (pending_pix.size() > 0 && !idle_now()) begin
					in_valid <= 1;
					{pix_x, pix_y} <= pending_pix.pop_front();
				end else
					in_valid <= 0;
			end
		end
	end

	// check results against the oldest prediction; stall the sink at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 0;
		else begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$error("unexpected result x=%0d y=%0d", out_x, out_y);
					errors++;
				end else begin
					point_t e;
					e = expected_points.pop_front();
					if (out_x !== e.ox) begin
						$error("out_x expected %0d actual %0d", e.ox, out_x);
						errors++;
					end
					if (out_y !== e.oy) begin
						$error("out_y expected %0d actual %0d", e.oy, out_y);
						errors++;
					end
					if (saturated !== e.sat) begin
						$error("saturated expected %0d actual %0d", e.sat, saturated);
						errors++;
					end
				end
			end
			out_ready <= !idle_now();
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// wait for the queue to drain and the pipeline to empty
	task automatic drain();
		while (pending_pix.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (spm_pkg::TOTAL_LAT + 4) @(posedge clk);
	endtask

	task automatic write_reg(spm_pkg::cfg_reg_t idx, logic [59:0] data);
		cfg_pend_idx = idx;
		cfg_pend_data = data;
		cfg_pend = 1;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready)) @(posedge clk);
		cfg_pend = 0;
		case (idx)
			spm_pkg::REG_ROW0: m_row[0] = data;
			spm_pkg::REG_ROW1: m_row[1] = data;
			spm_pkg::REG_ROW2: m_row[2] = data;
			spm_pkg::REG_SRC_C: s_cen = data[39:0];
			spm_pkg::REG_SRC_R: s_rad = data[19:0];
			spm_pkg::REG_DST_C: d_cen = data[39:0];
			spm_pkg::REG_DST_R: d_rad = data[19:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic push_pix(int x, int y);
		pix_req_t r;
		r.px = spm_pkg::COORD_BITS'(x);
		r.py = spm_pkg::COORD_BITS'(y);
		pending_pix.push_back(r);
	endtask

	// stimulus
	initial begin
		int per_phase;
		logic [59:0] row;
		errors = 0;
		cycles = 0;
		quiet = 0;
		cfg_pend = 0;
		cfg_pend_idx = spm_pkg::REG_ROW0;
		cfg_pend_data = '0;
		m_row[0] = 60'd262144;
		m_row[1] = 60'd262144 << 20;
		m_row[2] = 60'd262144 << 40;
		s_cen = '0;
		s_rad = 20'd16;
		d_cen = '0;
		d_rad = 20'd16;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset identity, field extremes
		push_pix(0, 0);
		push_pix(16383, 16383);
		push_pix(16383, 0);
		push_pix(0, 16383);
		push_pix(1, 2);
		push_pix(12345, 6789);
		drain();

		// zero denominator: third row zero
		write_reg(spm_pkg::REG_ROW2, '0);
		push_pix(0, 0);
		push_pix(5, 0);
		push_pix(0, 7);
		drain();

		// zero source radius, zero destination radius, wide centers
		write_reg(spm_pkg::REG_ROW2, 60'd262144 << 40);
		write_reg(spm_pkg::REG_SRC_R, '0);
		push_pix(0, 0);
		push_pix(100, 3);
		drain();
		write_reg(spm_pkg::REG_SRC_R, 60'(20'hFFFFF));
		write_reg(spm_pkg::REG_DST_R, '0);
		write_reg(spm_pkg::REG_DST_C, 60'(40'hFFFFF_FFFFF));
		push_pix(16383, 16383);
		push_pix(0, 0);
		drain();

		// quotient overflow: large scale and tiny denominator
		write_reg(spm_pkg::REG_DST_R, 60'(20'hFFFFF));
		write_reg(spm_pkg::REG_DST_C, '0);
		write_reg(spm_pkg::REG_SRC_R, 60'(20'd1));
		write_reg(spm_pkg::REG_SRC_C, 60'(40'hFFFFF_FFFFF));
		push_pix(0, 0);
		push_pix(16383, 16383);
		push_pix(8000, 100);
		drain();

		// random phases; the first keeps both sides busy throughout
		per_phase = N_RANDOM / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			quiet = (ph == 0);
			for (int i = 0; i < 3; i++) begin
				row = {rnd_coef(), rnd_coef(), rnd_coef()};
				write_reg(spm_pkg::cfg_reg_t'(i), row);
			end
			write_reg(spm_pkg::REG_SRC_C, 60'({20'($urandom), 20'($urandom)}));
			write_reg(spm_pkg::REG_SRC_R,
				60'((ph == PHASES - 1) ? 20'd1 : 20'($urandom_range(1, 20'hFFFFF))));
			write_reg(spm_pkg::REG_DST_C,
				60'((ph == 1) ? 40'hFFFFF_FFFFF : {20'($urandom), 20'($urandom)}));
			write_reg(spm_pkg::REG_DST_R,
				60'((ph == 2) ? 20'hFFFFF : 20'($urandom_range(1, 4096))));
			for (int i = 0; i < per_phase; i++)
				push_pix($urandom_range(0, 16383), $urandom_range(0, 16383));
			drain();
		end
		quiet = 0;

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
